/* src/top_k_min_replace_tracker_top_defines.svh */
// Assertion macros for the top-K tracker checker.
`ifndef TOP_K_MIN_REPLACE_TRACKER_TOP_DEFINES_SVH
`define TOP_K_MIN_REPLACE_TRACKER_TOP_DEFINES_SVH

// Check a property outside reset.
`define TKMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TKMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/tkmr_pkg.sv */
// Shared constants and types of the top-K tracker.
package tkmr_pkg;

  localparam int unsigned TOP_K   = 100;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned SUM_W   = 39;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned SLOT_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int unsigned CNT_W   = $clog2(TOP_K + 1);

  typedef struct packed {
    logic [ID_W-1:0]    item_id;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] min_val;
    logic [SLOT_W-1:0]  min_slot;
  } scan_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

/* src/tkmr_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
module tkmr_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 100,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* src/tkmr_min_scan.sv */
// Minimum search over the stored scores, one entry per cycle.
module tkmr_min_scan
  import tkmr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SCORE_W-1:0] rd_score_i,
  output logic               rd_en_o,
  output logic [SLOT_W-1:0]  rd_addr_o,
  output scan_stat_t         stat_o
);

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TOP_K - 1);

  logic               active_q;
  logic               done_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [SCORE_W-1:0] min_q;
  logic [SLOT_W-1:0]  min_slot_q;
  logic               take;

  always_comb begin
    rd_en_o   = start_i | (active_q & (idx_q != LAST));
    rd_addr_o = start_i ? '0 : idx_q + 1'b1;
    // strict compare keeps the lowest slot on ties
    take      = (idx_q == '0) || (rd_score_i < min_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (active_q) begin
        if (idx_q == LAST) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q && take) begin
      min_q      <= rd_score_i;
      min_slot_q <= idx_q;
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.min_val  = min_q;
  assign stat_o.min_slot = min_slot_q;

endmodule

/* src/top_k_min_replace_tracker_top.sv */
// Top-K tracker: keeps the TOP_K highest (score, id) pairs in a RAM.
// Append while not full: write the next free slot, then ST_EMIT loads the result word.
// Full table: scan all TOP_K slots for the minimum first; new words wait for ST_IDLE.
// The single RAM read port walking all TOP_K slots sets the rate once full.
// Reset clears fill count, score sum and handshake state; RAM contents stay unknown.
module top_k_min_replace_tracker_top
  import tkmr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SCORE_W-1:0] score_i,
  input  logic [ID_W-1:0]    item_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kept_o,
  output logic [FIELD_W-1:0] slot_o,
  output logic [FIELD_W-1:0] fill_count_o,
  output logic [SUM_W-1:0]   kept_sum_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] score_q;
  logic [ID_W-1:0]    id_q;
  logic               res_kept_q, res_kept_d;
  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic               res_load;
  logic               out_load;

  logic               in_fire;
  logic               full;
  logic               start;
  logic               gain;

  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  entry_t             rd_entry;
  scan_stat_t         stat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign full        = (count_q == CNT_W'(TOP_K));
  assign start       = in_fire & full;
  assign gain        = (score_q > stat.min_val);
  assign out_valid_o = out_valid_q;

  always_comb begin
    wr_en   = (in_fire & ~full) | ((state_q == ST_SCAN) & stat.done & gain);
    if (state_q == ST_IDLE) begin
      wr_addr         = count_q[SLOT_W-1:0];
      wr_data.item_id = item_id_i;
      wr_data.score   = score_i;
    end else begin
      wr_addr         = stat.min_slot;
      wr_data.item_id = id_q;
      wr_data.score   = score_q;
    end
  end

  tkmr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TOP_K),
    .ADDR_W(SLOT_W)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_entry)
  );

  tkmr_min_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .rd_score_i(rd_entry.score),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .stat_o    (stat)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    res_load    = 1'b0;
    res_kept_d  = 1'b0;
    res_slot_d  = '0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!full) begin
            // append at the next free slot
            count_d    = count_q + 1'b1;
            sum_d      = sum_q + SUM_W'(score_i);
            res_load   = 1'b1;
            res_kept_d = 1'b1;
            res_slot_d = count_q[SLOT_W-1:0];
            state_d    = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.done) begin
          res_load = 1'b1;
          if (gain) begin
            // replace the minimum, sum wraps at its width
            sum_d      = sum_q - SUM_W'(stat.min_val) + SUM_W'(score_q);
            res_kept_d = 1'b1;
            res_slot_d = stat.min_slot;
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      score_q <= score_i;
      id_q    <= item_id_i;
    end
    if (res_load) begin
      res_kept_q <= res_kept_d;
      res_slot_q <= res_slot_d;
    end
    if (out_load) begin
      kept_o       <= res_kept_q;
      slot_o       <= FIELD_W'(res_slot_q);
      fill_count_o <= FIELD_W'(count_q);
      kept_sum_o   <= sum_q;
    end
  end

endmodule

/* src/tkmr_checker.sv */
// Port-level checks of the top-K tracker, bound to the top level.
`include "top_k_min_replace_tracker_top_defines.svh"

module tkmr_checker
  import tkmr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               kept_o,
  input logic [FIELD_W-1:0] slot_o,
  input logic [FIELD_W-1:0] fill_count_o
);

  localparam logic [FIELD_W-1:0] FILL_MAX = FIELD_W'(TOP_K);

  `TKMR_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |-> out_valid_o !== 1'b1, "result word during reset")
  `TKMR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")
  `TKMR_ASSERT(a_reject_slot, out_valid_o && !kept_o |-> slot_o == '0, "rejected word with slot")
  `TKMR_ASSERT(a_fill_bound, out_valid_o |-> fill_count_o <= FILL_MAX, "fill count too large")
  `TKMR_ASSERT(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o, "second word taken")

endmodule

bind top_k_min_replace_tracker_top tkmr_checker u_tkmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kept_o      (kept_o),
  .slot_o      (slot_o),
  .fill_count_o(fill_count_o)
);
